// ===== sv/qco_pkg.sv =====
// Shared types and constants for the quad corner orderer.
`timescale 1ns / 1ps

package qco_pkg;

  // Number of corners in one quad.
  localparam int unsigned NUM_CORNERS = 4;

  // Number of distinct corner pairs that the angle sort compares.
  localparam int unsigned NUM_PAIRS = 6;

  // Index of one corner within a quad.
  typedef logic [1:0] corner_idx_t;

  // Corner pairs (first, second) compared by the angle sort, first < second.
  localparam corner_idx_t PAIR_FIRST [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam corner_idx_t PAIR_SECOND[NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // Angle class of a point seen from the centroid, in ascending angle order.
  typedef enum logic [1:0] {
    ACL_BELOW = 2'd0,  // dy < 0, angle in (-pi, 0)
    ACL_RIGHT = 2'd1,  // dy == 0 and dx >= 0, angle 0 (also the centroid itself)
    ACL_ABOVE = 2'd2,  // dy > 0, angle in (0, pi)
    ACL_LEFT  = 2'd3   // dy == 0 and dx < 0, angle pi
  } angle_class_e;

  // Valid flag that travels with each transaction between pipeline sections.
  typedef struct packed {
    logic valid;
  } stage_ctrl_t;

endpackage

// ===== sv/qco_angle_sort.sv =====
// Angle sort of four points around their centroid, three pipeline stages.
`timescale 1ns / 1ps

module qco_angle_sort #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  qco_pkg::stage_ctrl_t                    ctrl_i,
  input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] x_i,
  input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] y_i,
  output qco_pkg::stage_ctrl_t                    ctrl_o,
  output logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] x_o,
  output logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] y_o
);

  localparam int unsigned NC = qco_pkg::NUM_CORNERS;
  localparam int unsigned NP = qco_pkg::NUM_PAIRS;
  localparam int unsigned SW = COORD_BITS + 2;   // sum of four coordinates
  localparam int unsigned DW = COORD_BITS + 3;   // signed offset from centroid
  localparam int unsigned PW = 2 * DW;           // one cross product term
  localparam int unsigned CW = PW + 1;           // cross product difference

  // Stage 1: offsets from the centroid, scaled by four.
  logic [SW-1:0]                  sum_x_d, sum_y_d;
  logic signed [DW-1:0]           dx_d [NC];
  logic signed [DW-1:0]           dy_d [NC];
  logic                           valid_s1_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s1_q, y_s1_q;
  logic signed [DW-1:0]           dx_s1_q [NC];
  logic signed [DW-1:0]           dy_s1_q [NC];

  always_comb begin
    sum_x_d = '0;
    sum_y_d = '0;
    for (int i = 0; i < NC; i++) begin
      sum_x_d = sum_x_d + SW'(x_i[i]);
      sum_y_d = sum_y_d + SW'(y_i[i]);
    end
    for (int i = 0; i < NC; i++) begin
      dx_d[i] = $signed({1'b0, x_i[i], 2'b00}) - $signed({1'b0, sum_x_d});
      dy_d[i] = $signed({1'b0, y_i[i], 2'b00}) - $signed({1'b0, sum_y_d});
    end
  end

  // Stage 2: angle classes and the two products of each pairwise cross product.
  qco_pkg::angle_class_e          class_d [NC];
  logic signed [PW-1:0]           prod_ab_d [NP];
  logic signed [PW-1:0]           prod_ba_d [NP];
  logic                           valid_s2_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s2_q, y_s2_q;
  qco_pkg::angle_class_e          class_s2_q [NC];
  logic signed [PW-1:0]           prod_ab_s2_q [NP];
  logic signed [PW-1:0]           prod_ba_s2_q [NP];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      if (dy_s1_q[i] < 0) begin
        class_d[i] = qco_pkg::ACL_BELOW;
      end else if (dy_s1_q[i] > 0) begin
        class_d[i] = qco_pkg::ACL_ABOVE;
      end else if (dx_s1_q[i] < 0) begin
        class_d[i] = qco_pkg::ACL_LEFT;
      end else begin
        class_d[i] = qco_pkg::ACL_RIGHT;
      end
    end
    for (int p = 0; p < NP; p++) begin
      prod_ab_d[p] = dx_s1_q[qco_pkg::PAIR_FIRST[p]] * dy_s1_q[qco_pkg::PAIR_SECOND[p]];
      prod_ba_d[p] = dy_s1_q[qco_pkg::PAIR_FIRST[p]] * dx_s1_q[qco_pkg::PAIR_SECOND[p]];
    end
  end

  // Stage 3: strict angle order per pair, stable ranks, and the permutation.
  logic signed [CW-1:0]           cross_w [NP];
  logic [NC-1:0][NC-1:0]          less_w;     // less_w[a][b]: a sorts before b
  qco_pkg::corner_idx_t           rank_w [NC];
  logic [NC-1:0][COORD_BITS-1:0]  x_sorted_d, y_sorted_d;
  logic                           valid_s3_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s3_q, y_s3_q;

  always_comb begin
    less_w = '0;
    for (int p = 0; p < NP; p++) begin
      cross_w[p] = CW'(prod_ab_s2_q[p]) - CW'(prod_ba_s2_q[p]);
      if (class_s2_q[qco_pkg::PAIR_FIRST[p]] != class_s2_q[qco_pkg::PAIR_SECOND[p]]) begin
        less_w[qco_pkg::PAIR_FIRST[p]][qco_pkg::PAIR_SECOND[p]] =
            class_s2_q[qco_pkg::PAIR_FIRST[p]] < class_s2_q[qco_pkg::PAIR_SECOND[p]];
        less_w[qco_pkg::PAIR_SECOND[p]][qco_pkg::PAIR_FIRST[p]] =
            class_s2_q[qco_pkg::PAIR_SECOND[p]] < class_s2_q[qco_pkg::PAIR_FIRST[p]];
      end else if (class_s2_q[qco_pkg::PAIR_FIRST[p]] == qco_pkg::ACL_BELOW ||
                   class_s2_q[qco_pkg::PAIR_FIRST[p]] == qco_pkg::ACL_ABOVE) begin
        // Inside an open half plane the cross product sign decides.
        less_w[qco_pkg::PAIR_FIRST[p]][qco_pkg::PAIR_SECOND[p]] = cross_w[p] > 0;
        less_w[qco_pkg::PAIR_SECOND[p]][qco_pkg::PAIR_FIRST[p]] = cross_w[p] < 0;
      end
    end
    // An earlier point that does not sort after this one goes ahead of it,
    // which keeps equal angles in input order.
    for (int i = 0; i < NC; i++) begin
      rank_w[i] = '0;
      for (int j = 0; j < NC; j++) begin
        if ((j < i && !less_w[i][j]) || (j > i && less_w[j][i])) begin
          rank_w[i] = rank_w[i] + 2'd1;
        end
      end
    end
    x_sorted_d = '0;
    y_sorted_d = '0;
    for (int k = 0; k < NC; k++) begin
      for (int i = 0; i < NC; i++) begin
        if (rank_w[i] == qco_pkg::corner_idx_t'(k)) begin
          x_sorted_d[k] = x_s2_q[i];
          y_sorted_d[k] = y_s2_q[i];
        end
      end
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q <= 1'b0;
      valid_s2_q <= 1'b0;
      valid_s3_q <= 1'b0;
    end else begin
      valid_s1_q <= ctrl_i.valid;
      valid_s2_q <= valid_s1_q;
      valid_s3_q <= valid_s2_q;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    x_s1_q <= x_i;
    y_s1_q <= y_i;
    for (int i = 0; i < NC; i++) begin
      dx_s1_q[i]    <= dx_d[i];
      dy_s1_q[i]    <= dy_d[i];
      class_s2_q[i] <= class_d[i];
    end
    x_s2_q <= x_s1_q;
    y_s2_q <= y_s1_q;
    for (int p = 0; p < NP; p++) begin
      prod_ab_s2_q[p] <= prod_ab_d[p];
      prod_ba_s2_q[p] <= prod_ba_d[p];
    end
    x_s3_q <= x_sorted_d;
    y_s3_q <= y_sorted_d;
  end

  assign ctrl_o.valid = valid_s3_q;
  assign x_o          = x_s3_q;
  assign y_o          = y_s3_q;

`ifndef ASSERT_OFF
  // Every slot of the sorted quad is taken by exactly one point.
  a_ranks_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s2_q |-> (rank_w[0] != rank_w[1] && rank_w[0] != rank_w[2] &&
                    rank_w[0] != rank_w[3] && rank_w[1] != rank_w[2] &&
                    rank_w[1] != rank_w[3] && rank_w[2] != rank_w[3]))
    else $error("angle sort ranks collide");

  // The angle order never puts two points before each other.
  a_order_antisym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_s2_q |-> !((less_w[0][1] && less_w[1][0]) || (less_w[0][2] && less_w[2][0]) ||
                     (less_w[0][3] && less_w[3][0]) || (less_w[1][2] && less_w[2][1]) ||
                     (less_w[1][3] && less_w[3][1]) || (less_w[2][3] && less_w[3][2])))
    else $error("angle order is not antisymmetric");

  // Four identical points all sit on the centroid and keep their input order.
  a_stable_ties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_s1_q && dx_s1_q[0] == 0 && dx_s1_q[1] == 0 && dx_s1_q[2] == 0 &&
     dx_s1_q[3] == 0 && dy_s1_q[0] == 0 && dy_s1_q[1] == 0 && dy_s1_q[2] == 0 &&
     dy_s1_q[3] == 0)
    |=> (rank_w[0] == 2'd0 && rank_w[1] == 2'd1 && rank_w[2] == 2'd2 && rank_w[3] == 2'd3))
    else $error("tied angles lost input order");
`endif

endmodule

// ===== sv/qco_winding.sv =====
// Shoelace area sign and winding correction, two pipeline stages.
`timescale 1ns / 1ps

module qco_winding #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  qco_pkg::stage_ctrl_t                    ctrl_i,
  input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] x_i,
  input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] y_i,
  output qco_pkg::stage_ctrl_t                    ctrl_o,
  output logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] x_o,
  output logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] y_o
);

  localparam int unsigned NC = qco_pkg::NUM_CORNERS;
  localparam int unsigned MW = 2 * COORD_BITS;   // one shoelace product
  localparam int unsigned AW = MW + 2;           // sum of four products

  // Stage 1: the eight shoelace products, prev.x*cur.y and prev.y*cur.x.
  logic [MW-1:0]                  prod_xy_d [NC];
  logic [MW-1:0]                  prod_yx_d [NC];
  logic                           valid_s1_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s1_q, y_s1_q;
  logic [MW-1:0]                  prod_xy_s1_q [NC];
  logic [MW-1:0]                  prod_yx_s1_q [NC];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      prod_xy_d[k] = MW'(x_i[qco_pkg::corner_idx_t'(k + 3)]) * MW'(y_i[k]);
      prod_yx_d[k] = MW'(y_i[qco_pkg::corner_idx_t'(k + 3)]) * MW'(x_i[k]);
    end
  end

  // Stage 2: a negative area reverses the winding by swapping corners 1 and 3.
  logic [AW-1:0]                  sum_pos_w, sum_neg_w;
  logic                           reverse_w;
  logic [NC-1:0][COORD_BITS-1:0]  x_d, y_d;
  logic                           valid_s2_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s2_q, y_s2_q;

  always_comb begin
    sum_pos_w = '0;
    sum_neg_w = '0;
    for (int k = 0; k < NC; k++) begin
      sum_pos_w = sum_pos_w + AW'(prod_xy_s1_q[k]);
      sum_neg_w = sum_neg_w + AW'(prod_yx_s1_q[k]);
    end
    reverse_w = sum_pos_w < sum_neg_w;
    x_d = x_s1_q;
    y_d = y_s1_q;
    if (reverse_w) begin
      x_d[1] = x_s1_q[3];
      y_d[1] = y_s1_q[3];
      x_d[3] = x_s1_q[1];
      y_d[3] = y_s1_q[1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q <= 1'b0;
      valid_s2_q <= 1'b0;
    end else begin
      valid_s1_q <= ctrl_i.valid;
      valid_s2_q <= valid_s1_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_s1_q <= x_i;
    y_s1_q <= y_i;
    for (int k = 0; k < NC; k++) begin
      prod_xy_s1_q[k] <= prod_xy_d[k];
      prod_yx_s1_q[k] <= prod_yx_d[k];
    end
    x_s2_q <= x_d;
    y_s2_q <= y_d;
  end

  assign ctrl_o.valid = valid_s2_q;
  assign x_o          = x_s2_q;
  assign y_o          = y_s2_q;

endmodule

// ===== sv/qco_axis_orient.sv =====
// Long axis selection and final orientation, four pipeline stages.
`timescale 1ns / 1ps

module qco_axis_orient #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  qco_pkg::stage_ctrl_t                    ctrl_i,
  input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] x_i,
  input  logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] y_i,
  output qco_pkg::stage_ctrl_t                    ctrl_o,
  output logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] x_o,
  output logic [qco_pkg::NUM_CORNERS-1:0][COORD_BITS-1:0] y_o
);

  localparam int unsigned NC = qco_pkg::NUM_CORNERS;
  localparam int unsigned EW = COORD_BITS + 1;       // signed edge component
  localparam int unsigned QW = 2 * EW;               // product of two components
  localparam int unsigned SQ = 2 * COORD_BITS + 1;   // one squared component
  localparam int unsigned LW = SQ + 1;               // squared edge length
  localparam int unsigned XW = LW + 1;               // sum of the lengths of opposite edges

  // Stage 1: edge vectors, edge k runs from corner k+1 to corner k.
  logic signed [EW-1:0]           ex_d [NC];
  logic signed [EW-1:0]           ey_d [NC];
  logic                           valid_s1_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s1_q, y_s1_q;
  logic signed [EW-1:0]           ex_s1_q [NC];
  logic signed [EW-1:0]           ey_s1_q [NC];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      ex_d[k] = $signed({1'b0, x_i[k]}) - $signed({1'b0, x_i[qco_pkg::corner_idx_t'(k + 1)]});
      ey_d[k] = $signed({1'b0, y_i[k]}) - $signed({1'b0, y_i[qco_pkg::corner_idx_t'(k + 1)]});
    end
  end

  // Stage 2: squared edge components.
  logic signed [QW-1:0]           prod_x_w [NC];
  logic signed [QW-1:0]           prod_y_w [NC];
  logic [SQ-1:0]                  sq_x_d [NC];
  logic [SQ-1:0]                  sq_y_d [NC];
  logic                           valid_s2_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s2_q, y_s2_q;
  logic [SQ-1:0]                  sq_x_s2_q [NC];
  logic [SQ-1:0]                  sq_y_s2_q [NC];

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      prod_x_w[k] = ex_s1_q[k] * ex_s1_q[k];
      prod_y_w[k] = ey_s1_q[k] * ey_s1_q[k];
      sq_x_d[k]   = prod_x_w[k][SQ-1:0];
      sq_y_d[k]   = prod_y_w[k][SQ-1:0];
    end
  end

  // Stage 3: rotate by one when edges 1-2 and 3-0 form the longer axis.
  logic [LW-1:0]                  len_w [NC];
  logic [XW-1:0]                  axis_even_w, axis_odd_w;
  logic [NC-1:0][COORD_BITS-1:0]  x_rot1_d, y_rot1_d;
  logic                           valid_s3_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s3_q, y_s3_q;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      len_w[k] = LW'(sq_x_s2_q[k]) + LW'(sq_y_s2_q[k]);
    end
    axis_even_w = XW'(len_w[0]) + XW'(len_w[2]);
    axis_odd_w  = XW'(len_w[1]) + XW'(len_w[3]);
    for (int k = 0; k < NC; k++) begin
      if (axis_even_w < axis_odd_w) begin
        x_rot1_d[k] = x_s2_q[qco_pkg::corner_idx_t'(k + 1)];
        y_rot1_d[k] = y_s2_q[qco_pkg::corner_idx_t'(k + 1)];
      end else begin
        x_rot1_d[k] = x_s2_q[k];
        y_rot1_d[k] = y_s2_q[k];
      end
    end
  end

  // Stage 4: rotate by two when corner 2 has a smaller y than corner 0, or the same y and a smaller x.
  logic                           flip_w;
  logic [NC-1:0][COORD_BITS-1:0]  x_rot2_d, y_rot2_d;
  logic                           valid_s4_q;
  logic [NC-1:0][COORD_BITS-1:0]  x_s4_q, y_s4_q;

  always_comb begin
    flip_w = (y_s3_q[2] < y_s3_q[0]) || (y_s3_q[2] == y_s3_q[0] && x_s3_q[2] < x_s3_q[0]);
    for (int k = 0; k < NC; k++) begin
      if (flip_w) begin
        x_rot2_d[k] = x_s3_q[qco_pkg::corner_idx_t'(k + 2)];
        y_rot2_d[k] = y_s3_q[qco_pkg::corner_idx_t'(k + 2)];
      end else begin
        x_rot2_d[k] = x_s3_q[k];
        y_rot2_d[k] = y_s3_q[k];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q <= 1'b0;
      valid_s2_q <= 1'b0;
      valid_s3_q <= 1'b0;
      valid_s4_q <= 1'b0;
    end else begin
      valid_s1_q <= ctrl_i.valid;
      valid_s2_q <= valid_s1_q;
      valid_s3_q <= valid_s2_q;
      valid_s4_q <= valid_s3_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_s1_q <= x_i;
    y_s1_q <= y_i;
    for (int k = 0; k < NC; k++) begin
      ex_s1_q[k]   <= ex_d[k];
      ey_s1_q[k]   <= ey_d[k];
      sq_x_s2_q[k] <= sq_x_d[k];
      sq_y_s2_q[k] <= sq_y_d[k];
    end
    x_s2_q <= x_s1_q;
    y_s2_q <= y_s1_q;
    x_s3_q <= x_rot1_d;
    y_s3_q <= y_rot1_d;
    x_s4_q <= x_rot2_d;
    y_s4_q <= y_rot2_d;
  end

  assign ctrl_o.valid = valid_s4_q;
  assign x_o          = x_s4_q;
  assign y_o          = y_s4_q;

endmodule

// ===== sv/quad_corner_orderer_unit.sv =====
// Top level of the quad corner orderer: puts four points into canonical corner order.
//
//   Channel   Ports                               Direction  Transfer
//   command   start, busy, point0..3_x_i/_y_i     in         start high and busy low
//   result    done_o, corner0..3_x_o/_y_o         out        done_o high for one cycle
//
// One transaction enters per cycle. Its result passes through nine register stages:
// three for the angle sort, two for the area test, and four for axis and orientation.
// busy stays low, since the result side cannot stall and no stage ever holds.
// rst_ni clears only the valid bits of the pipeline; no clearing pass is needed.
`timescale 1ns / 1ps

module quad_corner_orderer_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] point0_x_i,
  input  logic [COORD_BITS-1:0] point0_y_i,
  input  logic [COORD_BITS-1:0] point1_x_i,
  input  logic [COORD_BITS-1:0] point1_y_i,
  input  logic [COORD_BITS-1:0] point2_x_i,
  input  logic [COORD_BITS-1:0] point2_y_i,
  input  logic [COORD_BITS-1:0] point3_x_i,
  input  logic [COORD_BITS-1:0] point3_y_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] corner0_x_o,
  output logic [COORD_BITS-1:0] corner0_y_o,
  output logic [COORD_BITS-1:0] corner1_x_o,
  output logic [COORD_BITS-1:0] corner1_y_o,
  output logic [COORD_BITS-1:0] corner2_x_o,
  output logic [COORD_BITS-1:0] corner2_y_o,
  output logic [COORD_BITS-1:0] corner3_x_o,
  output logic [COORD_BITS-1:0] corner3_y_o
);

  localparam int unsigned NC = qco_pkg::NUM_CORNERS;

  qco_pkg::stage_ctrl_t           in_ctrl, sort_ctrl, wind_ctrl, out_ctrl;
  logic [NC-1:0][COORD_BITS-1:0]  in_x, in_y;
  logic [NC-1:0][COORD_BITS-1:0]  sort_x, sort_y;
  logic [NC-1:0][COORD_BITS-1:0]  wind_x, wind_y;
  logic [NC-1:0][COORD_BITS-1:0]  out_x, out_y;

  // Command side: every start is taken.
  assign busy          = 1'b0;
  assign in_ctrl.valid = start && !busy;
  assign in_x          = {point3_x_i, point2_x_i, point1_x_i, point0_x_i};
  assign in_y          = {point3_y_i, point2_y_i, point1_y_i, point0_y_i};

  // Angle sort around the centroid.
  qco_angle_sort #(
    .COORD_BITS(COORD_BITS)
  ) u_sort (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (in_ctrl),
    .x_i    (in_x),
    .y_i    (in_y),
    .ctrl_o (sort_ctrl),
    .x_o    (sort_x),
    .y_o    (sort_y)
  );

  // Winding correction by area sign.
  qco_winding #(
    .COORD_BITS(COORD_BITS)
  ) u_wind (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sort_ctrl),
    .x_i    (sort_x),
    .y_i    (sort_y),
    .ctrl_o (wind_ctrl),
    .x_o    (wind_x),
    .y_o    (wind_y)
  );

  // Long axis and final orientation.
  qco_axis_orient #(
    .COORD_BITS(COORD_BITS)
  ) u_axis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (wind_ctrl),
    .x_i    (wind_x),
    .y_i    (wind_y),
    .ctrl_o (out_ctrl),
    .x_o    (out_x),
    .y_o    (out_y)
  );

  // Result side, straight from the last pipeline register.
  assign done_o      = out_ctrl.valid;
  assign corner0_x_o = out_x[0];
  assign corner0_y_o = out_y[0];
  assign corner1_x_o = out_x[1];
  assign corner1_y_o = out_y[1];
  assign corner2_x_o = out_x[2];
  assign corner2_y_o = out_y[2];
  assign corner3_x_o = out_x[3];
  assign corner3_y_o = out_y[3];

endmodule
